### sv/lpfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length-prefixed frame ring.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int CAP        = 4096;
    localparam int ADDR_W     = 12;
    localparam int USED_W     = 13;
    localparam int LEN_W      = 16;
    localparam int DROP_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int KIND_W     = 2;
    localparam int MAX_FRAME  = CAP - 2;

    localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_REJ  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POP_BYTE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POP_DROP  = 3'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Classification done by the front part.
    localparam logic [KIND_W-1:0] KIND_PUSH_FIRST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_NEXT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP        = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_len;
        logic             first_byte;
        logic [LEN_W-1:0] out_capacity;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          out_byte;
        logic                last_byte;
        logic [LEN_W-1:0]    frame_length;
        logic [USED_W-1:0]   used_bytes;
        logic [DROP_W-1:0]   dropped_count;
    } out_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        in_t               item;
    } cmd_t;

endpackage
`default_nettype wire

### sv/length_prefixed_frame_ring_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_ring_top
// Byte ring of whole frames behind two-byte little-endian length prefixes.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload          | transfer when
//  --------+-----------------------+------------------+----------------------
//  cmd     | cmd_valid / cmd_stall | in_t  (push/pop) | valid high, stall low
//  rsp     | rsp_valid / rsp_stall | out_t (one each) | valid high, stall low
//
// Steps: a continuation byte is written at issue; a mid-frame pop byte is
//   read from registered memory; an empty pop answers at issue; a frame start
//   push evicts oldest frames until it fits, then writes prefix and first byte;
//   a frame start pop reads the prefix, then drops the frame or reads a byte.
// Reset: pointers, counts and handshake state clear; the ring memory is
//   not cleared and holds garbage until written.
// Stalls: a two-entry queue decouples cmd from the sequencer; a stalled
//   result holds in the output register while the queue keeps filling.
// ----------------------------------------------------------------------------
module length_prefixed_frame_ring_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire lpfr_pkg::in_t  cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output lpfr_pkg::out_t      rsp
);

    logic           q_valid;
    logic           q_deq;
    lpfr_pkg::cmd_t q_cmd;

    // Front: accept and classify
    lpfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (cmd_valid),
        .stall   (cmd_stall),
        .item    (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_deq   (q_deq)
    );

    // Back: ring memory and sequencer
    lpfr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_deq   (q_deq),
        .valid   (rsp_valid),
        .stall   (rsp_stall),
        .result  (rsp)
    );

endmodule
`default_nettype wire

### sv/lpfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_front
// Accepts input transfers, tags each with its kind, and queues two deep.
// ----------------------------------------------------------------------------
module lpfr_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            valid,
    output logic                 stall,
    input  wire lpfr_pkg::in_t   item,
    output logic                 q_valid,
    output lpfr_pkg::cmd_t       q_cmd,
    input  wire logic            q_deq
);

    lpfr_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    lpfr_pkg::cmd_t classed;

    always_comb
    begin
        classed.item = item;
        if (item.opcode == lpfr_pkg::OP_POP)
        begin
            classed.kind = lpfr_pkg::KIND_POP;
        end
        else if (item.first_byte)
        begin
            classed.kind = lpfr_pkg::KIND_PUSH_FIRST;
        end
        else
        begin
            classed.kind = lpfr_pkg::KIND_PUSH_NEXT;
        end
    end

    assign stall   = (count_reg == 2'd2);
    assign push    = valid && !stall;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_deq;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_deq};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_deq |-> q_valid) else $error("dequeue from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_deq) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not advance");
`endif

endmodule
`default_nettype wire

### sv/lpfr_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfr_engine
// Back part: ring memory, pointers and the per-item sequencer.
// ----------------------------------------------------------------------------
module lpfr_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire lpfr_pkg::cmd_t  q_cmd,
    output logic                 q_deq,
    output logic                 valid,
    input  wire logic            stall,
    output lpfr_pkg::out_t       result
);

    localparam int AW = lpfr_pkg::ADDR_W;
    localparam int UW = lpfr_pkg::USED_W;
    localparam int LW = lpfr_pkg::LEN_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVCHK = 4'd1;
    localparam logic [3:0] S_ELO   = 4'd2;
    localparam logic [3:0] S_EHI   = 4'd3;
    localparam logic [3:0] S_WHI   = 4'd4;
    localparam logic [3:0] S_WDAT  = 4'd5;
    localparam logic [3:0] S_POPRD = 4'd6;
    localparam logic [3:0] S_PLO   = 4'd7;
    localparam logic [3:0] S_PHI   = 4'd8;
    localparam logic [3:0] S_PDAT  = 4'd9;

    localparam logic [UW-1:0] CAP_U = UW'(lpfr_pkg::CAP);

    logic [7:0]         mem [lpfr_pkg::CAP];
    logic [7:0]         rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [31:0]        drop_reg, drop_next;
    logic [LW-1:0]      push_rem_reg, push_rem_next;
    logic               push_rej_reg, push_rej_next;
    logic [LW-1:0]      pop_rem_reg, pop_rem_next;
    logic [LW-1:0]      pop_len_reg, pop_len_next;
    logic [7:0]         lo_reg, lo_next;
    logic [LW-1:0]      len_reg, len_next;
    lpfr_pkg::cmd_t     cur_reg, cur_next;
    logic               valid_reg, valid_next;
    lpfr_pkg::out_t     result_reg, result_next;

    logic               slot_free;
    logic [LW-1:0]      rd_len;
    logic [LW-1:0]      rel_len;
    logic               rel_all;
    logic [AW-1:0]      rel_tail;
    logic [UW-1:0]      rel_used;
    logic [UW-1:0]      free_bytes;
    logic [LW:0]        need_bytes;
    logic               emit;
    logic [2:0]         r_status;
    logic [7:0]         r_byte;
    logic               r_last;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      flen;

    assign slot_free  = !valid_reg || !stall;
    assign rd_len     = {rd_data_reg, lo_reg};
    assign flen       = cur_reg.item.frame_len;
    assign free_bytes = CAP_U - used_reg;
    assign need_bytes = {1'b0, flen} + 17'd2;

    // Release of the oldest frame, len excludes the prefix
    assign rel_len  = (state_reg == S_PDAT) ? len_reg : rd_len;
    assign rel_all  = ({1'b0, rel_len} + 17'd2) > {4'b0, used_reg};
    assign rel_tail = rel_all ? head_reg : (tail_reg + AW'(2) + rel_len[AW-1:0]);
    assign rel_used = rel_all ? '0 : (used_reg - (rel_len[UW-1:0] + UW'(2)));

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        used_next     = used_reg;
        drop_next     = drop_reg;
        push_rem_next = push_rem_reg;
        push_rej_next = push_rej_reg;
        pop_rem_next  = pop_rem_reg;
        pop_len_next  = pop_len_reg;
        lo_next       = lo_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        q_deq         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = tail_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_data       = 8'd0;
        emit          = 1'b0;
        r_status      = lpfr_pkg::ST_PUSH_OK;
        r_byte        = 8'd0;
        r_last        = 1'b0;
        r_len         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_deq    = 1'b1;
                    cur_next = q_cmd;
                    unique case (q_cmd.kind)
                        lpfr_pkg::KIND_PUSH_FIRST:
                        begin
                            if (q_cmd.item.frame_len == '0 ||
                                q_cmd.item.frame_len > LW'(lpfr_pkg::MAX_FRAME))
                            begin
                                drop_next     = drop_reg + 32'd1;
                                push_rej_next = 1'b1;
                                push_rem_next = (q_cmd.item.frame_len == '0) ? '0 :
                                                q_cmd.item.frame_len - LW'(1);
                                emit          = 1'b1;
                                r_status      = lpfr_pkg::ST_PUSH_REJ;
                            end
                            else
                            begin
                                state_next = S_EVCHK;
                            end
                        end
                        lpfr_pkg::KIND_PUSH_NEXT:
                        begin
                            emit = 1'b1;
                            if (push_rem_reg == '0)
                            begin
                                r_status = lpfr_pkg::ST_PUSH_REJ;
                            end
                            else if (push_rej_reg)
                            begin
                                push_rem_next = push_rem_reg - LW'(1);
                                r_status      = lpfr_pkg::ST_PUSH_REJ;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = head_reg - push_rem_reg[AW-1:0];
                                wr_data       = q_cmd.item.data_byte;
                                push_rem_next = push_rem_reg - LW'(1);
                                r_status      = lpfr_pkg::ST_PUSH_OK;
                            end
                        end
                        default:
                        begin
                            if (pop_rem_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = tail_reg - pop_rem_reg[AW-1:0];
                                state_next = S_POPRD;
                            end
                            else if (used_reg == '0)
                            begin
                                emit     = 1'b1;
                                r_status = lpfr_pkg::ST_POP_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = tail_reg;
                                state_next = S_PLO;
                            end
                        end
                    endcase
                end
            end
            S_EVCHK:
            begin
                if ({4'b0, free_bytes} < need_bytes)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = tail_reg;
                    state_next = S_ELO;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_data    = flen[7:0];
                    state_next = S_WHI;
                end
            end
            S_ELO:
            begin
                lo_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = tail_reg + AW'(1);
                state_next = S_EHI;
            end
            S_EHI:
            begin
                tail_next  = rel_tail;
                used_next  = rel_used;
                drop_next  = drop_reg + 32'd1;
                state_next = S_EVCHK;
            end
            S_WHI:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg + AW'(1);
                wr_data    = flen[15:8];
                state_next = S_WDAT;
            end
            S_WDAT:
            begin
                wr_en         = 1'b1;
                wr_addr       = head_reg + AW'(2);
                wr_data       = cur_reg.item.data_byte;
                head_next     = head_reg + AW'(2) + flen[AW-1:0];
                used_next     = used_reg + flen[UW-1:0] + UW'(2);
                push_rej_next = 1'b0;
                push_rem_next = flen - LW'(1);
                emit          = 1'b1;
                r_status      = lpfr_pkg::ST_PUSH_OK;
                state_next    = S_IDLE;
            end
            S_POPRD:
            begin
                pop_rem_next = pop_rem_reg - LW'(1);
                emit         = 1'b1;
                r_status     = lpfr_pkg::ST_POP_BYTE;
                r_byte       = rd_data_reg;
                r_last       = (pop_rem_reg == LW'(1));
                r_len        = pop_len_reg;
                state_next   = S_IDLE;
            end
            S_PLO:
            begin
                lo_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = tail_reg + AW'(1);
                state_next = S_PHI;
            end
            S_PHI:
            begin
                if (rd_len == '0 || rd_len > cur_reg.item.out_capacity)
                begin
                    tail_next  = rel_tail;
                    used_next  = rel_used;
                    drop_next  = drop_reg + 32'd1;
                    emit       = 1'b1;
                    r_status   = lpfr_pkg::ST_POP_DROP;
                    r_len      = rd_len;
                    state_next = S_IDLE;
                end
                else
                begin
                    len_next   = rd_len;
                    rd_en      = 1'b1;
                    rd_addr    = tail_reg + AW'(2);
                    state_next = S_PDAT;
                end
            end
            S_PDAT:
            begin
                tail_next    = rel_tail;
                used_next    = rel_used;
                pop_len_next = len_reg;
                pop_rem_next = len_reg - LW'(1);
                emit         = 1'b1;
                r_status     = lpfr_pkg::ST_POP_BYTE;
                r_byte       = rd_data_reg;
                r_last       = (len_reg == LW'(1));
                r_len        = len_reg;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next  = valid_reg && stall;
        result_next = result_reg;
        if (emit)
        begin
            valid_next                = 1'b1;
            result_next.status        = r_status;
            result_next.out_byte      = r_byte;
            result_next.last_byte     = r_last;
            result_next.frame_length  = r_len;
            result_next.used_bytes    = used_next;
            result_next.dropped_count = drop_next;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            used_reg     <= '0;
            drop_reg     <= '0;
            push_rem_reg <= '0;
            push_rej_reg <= 1'b0;
            pop_rem_reg  <= '0;
            pop_len_reg  <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            used_reg     <= used_next;
            drop_reg     <= drop_next;
            push_rem_reg <= push_rem_next;
            push_rej_reg <= push_rej_next;
            pop_rem_reg  <= pop_rem_next;
            pop_len_reg  <= pop_len_next;
            valid_reg    <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg - tail_reg) == used_reg[AW-1:0])
        else $error("head/tail distance disagrees with used count");
    a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CAP_U) else $error("used count above capacity");
    a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg == $past(drop_reg) || drop_reg == $past(drop_reg) + 32'd1)
        else $error("drop count jumped");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && stall) |-> !emit) else $error("result lost while stalled");
`endif

endmodule
`default_nettype wire

### tb/length_prefixed_frame_ring_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_ring_top_test
// Self-checking bench for the frame ring: a behavioral ring model predicts
// every response; directed frames, rejects and evictions come first, then
// random frame traffic under several sender idle / receiver stall mixes.
// ----------------------------------------------------------------------------
module length_prefixed_frame_ring_top_test;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    lpfr_pkg::in_t  cmd = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    lpfr_pkg::out_t rsp;

    length_prefixed_frame_ring_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Ring model state, plus a map of bytes actually written so that the
    // stimulus never makes the block read memory it has not filled.
    logic [7:0]  ring_mem [lpfr_pkg::CAP];
    bit          ring_written [lpfr_pkg::CAP];
    int unsigned ring_head, ring_tail, ring_used;
    logic [31:0] ring_drops;
    int unsigned push_left, pop_left, pop_len;
    bit          push_rej;

    lpfr_pkg::out_t expected_rsp_q[$];
    int   error_count;
    int   item_count;
    int   rsp_count;
    int   idle_pct;
    int   stall_pct;

    function automatic int unsigned prefix_of(int unsigned p);
        return ring_mem[p % lpfr_pkg::CAP] | (ring_mem[(p + 1) % lpfr_pkg::CAP] << 8);
    endfunction

    function automatic void release_oldest(int unsigned len);
        if (len + 2 > ring_used) begin
            ring_tail = ring_head;
            ring_used = 0;
        end
        else begin
            ring_tail = (ring_tail + 2 + len) % lpfr_pkg::CAP;
            ring_used -= 2 + len;
        end
    endfunction

    function automatic void store_byte(int unsigned a, logic [7:0] b);
        ring_mem[a % lpfr_pkg::CAP] = b;
        ring_written[a % lpfr_pkg::CAP] = 1'b1;
    endfunction

    // Would this command make the block read a never-written byte?
    function automatic bit reads_unwritten(lpfr_pkg::in_t it);
        int unsigned t, u, len;
        t = ring_tail;
        u = ring_used;
        if (it.opcode == lpfr_pkg::OP_PUSH) begin
            if (!it.first_byte || it.frame_len == 0 || it.frame_len + 2 > lpfr_pkg::CAP)
                return 1'b0;
            while (lpfr_pkg::CAP - u < it.frame_len + 2) begin
                if (!ring_written[t] || !ring_written[(t + 1) % lpfr_pkg::CAP])
                    return 1'b1;
                len = ring_mem[t] | (ring_mem[(t + 1) % lpfr_pkg::CAP] << 8);
                if (len + 2 > u) begin
                    u = 0;
                end
                else begin
                    t = (t + 2 + len) % lpfr_pkg::CAP;
                    u -= 2 + len;
                end
            end
            return 1'b0;
        end
        if (pop_left != 0)
            return !ring_written[(ring_tail + lpfr_pkg::CAP - pop_left % lpfr_pkg::CAP)
                                 % lpfr_pkg::CAP];
        if (ring_used == 0)
            return 1'b0;
        if (!ring_written[t] || !ring_written[(t + 1) % lpfr_pkg::CAP])
            return 1'b1;
        len = prefix_of(t);
        if (len != 0 && len <= it.out_capacity)
            return !ring_written[(t + 2) % lpfr_pkg::CAP];
        return 1'b0;
    endfunction

    function automatic lpfr_pkg::out_t predict_ring(lpfr_pkg::in_t it);
        lpfr_pkg::out_t r;
        int unsigned len;
        r = '0;
        if (it.opcode == lpfr_pkg::OP_PUSH) begin
            if (it.first_byte) begin
                if (it.frame_len == 0 || it.frame_len + 2 > lpfr_pkg::CAP) begin
                    ring_drops++;
                    push_rej = 1'b1;
                    push_left = (it.frame_len > 0) ? it.frame_len - 1 : 0;
                    r.status = lpfr_pkg::ST_PUSH_REJ;
                end
                else begin
                    while (lpfr_pkg::CAP - ring_used < it.frame_len + 2) begin
                        release_oldest(prefix_of(ring_tail));
                        ring_drops++;
                    end
                    store_byte(ring_head, it.frame_len[7:0]);
                    store_byte(ring_head + 1, it.frame_len[15:8]);
                    store_byte(ring_head + 2, it.data_byte);
                    ring_head = (ring_head + 2 + it.frame_len) % lpfr_pkg::CAP;
                    ring_used += 2 + it.frame_len;
                    push_rej = 1'b0;
                    push_left = it.frame_len - 1;
                    r.status = lpfr_pkg::ST_PUSH_OK;
                end
            end
            else if (push_left == 0) begin
                r.status = lpfr_pkg::ST_PUSH_REJ;
            end
            else if (push_rej) begin
                push_left--;
                r.status = lpfr_pkg::ST_PUSH_REJ;
            end
            else begin
                store_byte(ring_head + lpfr_pkg::CAP - push_left % lpfr_pkg::CAP,
                           it.data_byte);
                push_left--;
                r.status = lpfr_pkg::ST_PUSH_OK;
            end
        end
        else if (pop_left != 0) begin
            r.out_byte = ring_mem[(ring_tail + lpfr_pkg::CAP - pop_left % lpfr_pkg::CAP)
                                  % lpfr_pkg::CAP];
            pop_left--;
            r.last_byte = (pop_left == 0);
            r.frame_length = 16'(pop_len);
            r.status = lpfr_pkg::ST_POP_BYTE;
        end
        else if (ring_used == 0) begin
            r.status = lpfr_pkg::ST_POP_EMPTY;
        end
        else begin
            len = prefix_of(ring_tail);
            if (len == 0 || len > it.out_capacity) begin
                release_oldest(len);
                ring_drops++;
                r.frame_length = 16'(len);
                r.status = lpfr_pkg::ST_POP_DROP;
            end
            else begin
                r.out_byte = ring_mem[(ring_tail + 2) % lpfr_pkg::CAP];
                release_oldest(len);
                pop_len = len;
                pop_left = len - 1;
                r.last_byte = (pop_left == 0);
                r.frame_length = 16'(len);
                r.status = lpfr_pkg::ST_POP_BYTE;
            end
        end
        r.used_bytes = 13'(ring_used);
        r.dropped_count = ring_drops;
        return r;
    endfunction

    // One command transfer. A command that would read unfilled memory is
    // turned into a plain continuation byte, which never reads the ring.
    task automatic send_item(lpfr_pkg::in_t it);
        bit taken;
        if (reads_unwritten(it)) begin
            it.opcode = lpfr_pkg::OP_PUSH;
            it.first_byte = 1'b0;
        end
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        expected_rsp_q.push_back(predict_ring(it));
        cmd <= it;
        cmd_valid <= 1'b1;
        do begin
            @(negedge clk);
            taken = !cmd_stall;
            @(posedge clk);
        end while (!taken);
        item_count++;
    endtask

    function automatic lpfr_pkg::in_t push_item(bit first, logic [15:0] len,
                                                logic [7:0] b);
        lpfr_pkg::in_t it;
        it = '0;
        it.opcode = lpfr_pkg::OP_PUSH;
        it.first_byte = first;
        it.frame_len = len;
        it.data_byte = b;
        it.out_capacity = 16'($urandom);
        return it;
    endfunction

    function automatic lpfr_pkg::in_t random_item();
        lpfr_pkg::in_t it;
        it = '0;
        it.opcode = 1'($urandom);
        it.data_byte = 8'($urandom);
        it.frame_len = 16'($urandom);
        it.first_byte = 1'($urandom);
        it.out_capacity = 16'($urandom);
        return it;
    endfunction

    function automatic lpfr_pkg::in_t pop_item(logic [15:0] ocap);
        lpfr_pkg::in_t it;
        it = random_item();
        it.opcode = lpfr_pkg::OP_POP;
        it.out_capacity = ocap;
        return it;
    endfunction

    // Push a frame, sending only the first `sent` of its bytes.
    task automatic push_frame(logic [15:0] len, int sent);
        send_item(push_item(1'b1, len, 8'($urandom)));
        for (int i = 1; i < sent; i++)
            send_item(push_item(1'b0, 16'($urandom), 8'($urandom)));
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: sample at the falling edge what the next rising edge takes.
    logic           rsp_take;
    lpfr_pkg::out_t rsp_seen;
    lpfr_pkg::out_t rsp_want;
    always begin
        @(negedge clk);
        rsp_take = rst_n && rsp_valid && !rsp_stall;
        rsp_seen = rsp;
        @(posedge clk);
        if (rsp_take) begin
            rsp_count++;
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: response exp none got %h", $time, rsp_seen);
                error_count++;
            end
            else begin
                rsp_want = expected_rsp_q.pop_front();
                if (rsp_seen.status !== rsp_want.status) begin
                    $display("%0t: status exp %0d got %0d", $time,
                             rsp_want.status, rsp_seen.status);
                    error_count++;
                end
                if (rsp_seen.out_byte !== rsp_want.out_byte) begin
                    $display("%0t: out_byte exp %h got %h", $time,
                             rsp_want.out_byte, rsp_seen.out_byte);
                    error_count++;
                end
                if (rsp_seen.last_byte !== rsp_want.last_byte) begin
                    $display("%0t: last_byte exp %b got %b", $time,
                             rsp_want.last_byte, rsp_seen.last_byte);
                    error_count++;
                end
                if (rsp_seen.frame_length !== rsp_want.frame_length) begin
                    $display("%0t: frame_length exp %0d got %0d", $time,
                             rsp_want.frame_length, rsp_seen.frame_length);
                    error_count++;
                end
                if (rsp_seen.used_bytes !== rsp_want.used_bytes) begin
                    $display("%0t: used_bytes exp %0d got %0d", $time,
                             rsp_want.used_bytes, rsp_seen.used_bytes);
                    error_count++;
                end
                if (rsp_seen.dropped_count !== rsp_want.dropped_count) begin
                    $display("%0t: dropped_count exp %0d got %0d", $time,
                             rsp_want.dropped_count, rsp_seen.dropped_count);
                    error_count++;
                end
            end
        end
        rsp_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    // Field extremes, rejects, stray bytes, eviction of an abandoned frame.
    task automatic test_directed();
        send_item(pop_item(16'h0000));              // pop from empty ring
        send_item(push_item(1'b0, 16'hffff, 8'hff)); // stray byte, no frame
        push_frame(16'd0, 1);                        // empty frame rejected
        push_frame(16'hffff, 3);                     // too big, bytes refused
        push_frame(16'(lpfr_pkg::MAX_FRAME + 1), 1); // one past the limit
        send_item(push_item(1'b1, 16'd1, 8'h00));
        send_item(push_item(1'b1, 16'd3, 8'hff));
        send_item(push_item(1'b0, 16'd0, 8'ha5));
        send_item(push_item(1'b0, 16'hffff, 8'h5a));
        send_item(pop_item(16'h0000));              // over reader size: drop
        send_item(pop_item(16'hffff));
        send_item(push_item(1'b1, 16'd2, 8'h11));   // push during a pop
        send_item(pop_item(16'h0000));              // mid-frame ignores size
        send_item(pop_item(16'h0003));
        send_item(push_item(1'b0, 16'd0, 8'h22));
        // Largest frame, abandoned at once; the next frame must evict it.
        send_item(push_item(1'b1, 16'(lpfr_pkg::MAX_FRAME), 8'h33));
        push_frame(16'd4, 4);
        send_item(pop_item(16'hffff));
        send_item(pop_item(16'hffff));
        repeat (5) send_item(pop_item(16'hffff));
        wait_drained();
    endtask

    // Mostly complete frames of random content, with pop bursts, rejects,
    // abandoned frames and fully random commands mixed in.
    task automatic test_random_traffic(int n, int idle, int stall);
        int pick, len;
        idle_pct = idle;
        stall_pct = stall;
        n += item_count;
        while (item_count < n) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                pick = $urandom_range(99);
                len = (pick < 90) ? $urandom_range(1, 24) :
                      (pick < 98) ? $urandom_range(25, 300) : $urandom_range(301, 1500);
                push_frame(16'(len), len);
            end
            else if (pick < 55) begin
                push_frame($urandom_range(1) ? 16'd0 :
                           16'($urandom_range(lpfr_pkg::CAP - 1, 65535)),
                           $urandom_range(1, 4));
            end
            else if (pick < 62) begin
                len = $urandom_range(2, 30);
                push_frame(16'(len), $urandom_range(1, len - 1));
            end
            else if (pick < 90) begin
                repeat ($urandom_range(1, 10))
                    send_item(pop_item(($urandom_range(99) < 80) ? 16'hffff :
                                       16'($urandom)));
            end
            else begin
                send_item(random_item());
            end
            if ($urandom_range(199) == 0)
                wait_drained();
        end
        wait_drained();
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // Sender holds off until the ring has answered everything.
    task automatic test_drained_pause();
        push_frame(16'd5, 5);
        wait_drained();
        repeat (3) send_item(pop_item(16'hffff));
        wait_drained();
    endtask

    initial begin
        error_count = 0;
        item_count = 0;
        rsp_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        ring_head = 0;
        ring_tail = 0;
        ring_used = 0;
        ring_drops = '0;
        push_left = 0;
        pop_left = 0;
        pop_len = 0;
        push_rej = 1'b0;
        for (int i = 0; i < lpfr_pkg::CAP; i++)
            ring_written[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drained_pause();
        test_random_traffic(400, 0, 0);
        test_random_traffic(400, 72, 0);
        test_random_traffic(400, 0, 72);
        test_random_traffic(400, 8, 8);

        cmd_valid <= 1'b0;
        repeat (50) @(posedge clk);
        $display("Covered %0d commands and %0d responses: frames, rejects, evictions,",
                 item_count, rsp_count);
        $display("pop drops and random traffic under idle and stall mixes.");
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
